// ===== src/plm_pkg.sv =====
// Shared constants, codes and types of the pooled linked list manager.
package plm_pkg;

    localparam int NODE_COUNT = 16;
    localparam int MAX_OUT    = 16;
    localparam int CAP_LIMIT  = (NODE_COUNT < MAX_OUT) ? NODE_COUNT : MAX_OUT;
    localparam int IDX_W      = $clog2(NODE_COUNT);
    localparam int LEN_W      = 5;
    localparam int VAL_W      = 32;
    localparam int OP_W       = 3;
    localparam int STATUS_W   = 2;
    localparam int IN_W       = OP_W + LEN_W + VAL_W;
    localparam int OUT_W      = STATUS_W + LEN_W + VAL_W + VAL_W + 1;
    localparam int IN_BYTES_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT_HEAD = 3'd0,
        OP_INSERT_TAIL = 3'd1,
        OP_INSERT_AT   = 3'd2,
        OP_REMOVE_HEAD = 3'd3,
        OP_REMOVE_TAIL = 3'd4,
        OP_REMOVE_AT   = 3'd5,
        OP_LIST_ALL    = 3'd6
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_BAD_INDEX = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_ROTATE
    } cell_op_t;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        cell_op_t               op;
        logic [IDX_W-1:0]       index;
    } cell_cmd_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_APPLY,
        FSM_REPORT,
        FSM_LIST
    } fsm_state_t;

endpackage

// ===== src/plm_cell.sv =====
// One element cell: holds a value and takes a neighbor's, the new or the head value as the row changes.
module plm_cell (
    input  logic                                aclk,
    input  plm_pkg::cell_cmd_t                  cmd,
    input  logic [plm_pkg::IDX_W-1:0]           my_index,
    input  logic [plm_pkg::VAL_W-1:0]           prev_value,
    input  logic [plm_pkg::VAL_W-1:0]           next_value,
    input  logic [plm_pkg::VAL_W-1:0]           head_value,
    input  logic [plm_pkg::VAL_W-1:0]           new_value,
    output logic [plm_pkg::VAL_W-1:0]           value
);

    logic [plm_pkg::VAL_W-1:0] value_reg;
    logic [plm_pkg::VAL_W-1:0] value_next;

    always_comb begin
        value_next = value_reg;
        case (cmd.op)
            plm_pkg::CELL_INSERT: begin
                if (my_index == cmd.index) begin
                    value_next = new_value;
                end else if (my_index > cmd.index) begin
                    value_next = prev_value;
                end
            end
            plm_pkg::CELL_REMOVE: begin
                if (my_index >= cmd.index) begin
                    value_next = next_value;
                end
            end
            plm_pkg::CELL_ROTATE: begin
                // The last occupied cell wraps the head around to the back.
                if (my_index == cmd.index) begin
                    value_next = head_value;
                end else if (my_index < cmd.index) begin
                    value_next = next_value;
                end
            end
            default: begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// ===== src/plm_chain.sv =====
// Row of element cells holding the list in order, head in cell zero.
module plm_chain (
    input  logic                                aclk,
    input  plm_pkg::cell_cmd_t                  cmd,
    input  logic [plm_pkg::VAL_W-1:0]           new_value,
    input  logic [plm_pkg::IDX_W-1:0]           tail_index,
    output logic [plm_pkg::VAL_W-1:0]           head_value,
    output logic [plm_pkg::VAL_W-1:0]           tail_value
);

    logic [plm_pkg::VAL_W-1:0] cell_values [plm_pkg::NODE_COUNT];

    for (genvar i = 0; i < plm_pkg::NODE_COUNT; i++) begin : g_cell
        logic [plm_pkg::VAL_W-1:0] prev_value;
        logic [plm_pkg::VAL_W-1:0] next_value;

        if (i == 0) begin : g_first
            assign prev_value = '0;
        end else begin : g_mid_prev
            assign prev_value = cell_values[i-1];
        end

        if (i == plm_pkg::NODE_COUNT - 1) begin : g_last
            assign next_value = '0;
        end else begin : g_mid_next
            assign next_value = cell_values[i+1];
        end

        plm_cell u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .my_index   (plm_pkg::IDX_W'(i)),
            .prev_value (prev_value),
            .next_value (next_value),
            .head_value (cell_values[0]),
            .new_value  (new_value),
            .value      (cell_values[i])
        );
    end

    assign head_value = cell_values[0];
    assign tail_value = cell_values[tail_index];

endmodule

// ===== src/pooled_linked_list_manager.sv =====
// Pooled linked list manager: command decode, length bookkeeping and result stream.
//
// The list is held in order in a row of 16 cells, head first; inserts and removes shift the
// cells behind the affected position by one place, all in the same step. A command passes
// through accept, apply and report before its result beat, and a listing sends one beat per
// element, since the row rotates by one cell for each element sent.
// A new command is taken once the previous one has produced its last result; the result
// register holds a beat until the consumer takes it. The capacity register can be written at
// any time the block is idle and takes effect on the next command.

module pooled_linked_list_manager (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [plm_pkg::LEN_W-1:0]           cfg_data,     // list_capacity

    input  logic                                s_tvalid,
    output logic                                s_tready,
    // opcode [2:0], position [7:3], value [39:8]
    input  logic [plm_pkg::IN_BYTES_W-1:0]      s_tdata,

    output logic                                m_tvalid,
    input  logic                                m_tready,
    // status [1:0], element_count [6:2], element_value [38:7], tail_value [70:39],
    // list_empty [71]
    output logic [plm_pkg::OUT_BYTES_W-1:0]     m_tdata,
    output logic                                m_tlast
);

    localparam int LEN_W = plm_pkg::LEN_W;
    localparam int IDX_W = plm_pkg::IDX_W;
    localparam int VAL_W = plm_pkg::VAL_W;

    plm_pkg::fsm_state_t            state_reg, state_next;
    logic [plm_pkg::OP_W-1:0]       op_reg, op_next;
    logic [LEN_W-1:0]               pos_reg, pos_next;
    logic [VAL_W-1:0]               val_reg, val_next;
    logic [LEN_W-1:0]               length_reg, length_next;
    logic [LEN_W-1:0]               capacity_reg;
    plm_pkg::status_t               status_reg, status_next;
    logic [LEN_W-1:0]               count_reg, count_next;
    logic [VAL_W-1:0]               list_tail_reg, list_tail_next;
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [plm_pkg::OUT_BYTES_W-1:0] m_tdata_reg, m_tdata_next;
    logic                           m_tlast_reg, m_tlast_next;

    plm_pkg::cell_cmd_t             cmd;
    logic [VAL_W-1:0]               head_value;
    logic [VAL_W-1:0]               tail_value;
    logic [IDX_W-1:0]               last_index;
    logic [LEN_W-1:0]               work_cap;
    logic [LEN_W:0]                 len_plus_one;
    logic [LEN_W:0]                 pos_wide;
    logic [LEN_W-1:0]               len_minus_one;
    logic                           list_is_empty;
    logic                           out_free;
    logic                           in_accept;
    logic                           pos_bad_insert;
    logic                           pos_bad_remove;
    logic                           list_last;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == plm_pkg::FSM_IDLE);
    assign in_accept = s_tvalid && s_tready;

    assign work_cap = (capacity_reg > LEN_W'(plm_pkg::CAP_LIMIT)) ?
                      LEN_W'(plm_pkg::CAP_LIMIT) : capacity_reg;
    assign len_plus_one   = {1'b0, length_reg} + (LEN_W+1)'(1);
    assign pos_wide       = {1'b0, pos_reg};
    assign len_minus_one  = length_reg - LEN_W'(1);
    assign last_index     = len_minus_one[IDX_W-1:0];
    assign list_is_empty  = (length_reg == '0);
    assign out_free       = !m_tvalid_reg || m_tready;
    assign pos_bad_insert = (pos_reg == '0) || (pos_wide > len_plus_one);
    assign pos_bad_remove = (pos_reg == '0) || (pos_reg > length_reg);
    assign list_last      = (count_reg == len_minus_one);

    plm_chain u_chain (
        .aclk       (aclk),
        .cmd        (cmd),
        .new_value  (val_reg),
        .tail_index (last_index),
        .head_value (head_value),
        .tail_value (tail_value)
    );

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        length_next    = length_reg;
        status_next    = status_reg;
        count_next     = count_reg;
        list_tail_next = list_tail_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tlast_next   = m_tlast_reg;
        cmd.op         = plm_pkg::CELL_HOLD;
        cmd.index      = '0;

        case (state_reg)
            plm_pkg::FSM_IDLE: begin
                if (in_accept) begin
                    op_next    = s_tdata[2:0];
                    pos_next   = s_tdata[7:3];
                    val_next   = s_tdata[39:8];
                    state_next = plm_pkg::FSM_APPLY;
                end
            end
            plm_pkg::FSM_APPLY: begin
                status_next = plm_pkg::ST_OK;
                state_next  = plm_pkg::FSM_REPORT;
                case (op_reg)
                    plm_pkg::OP_INSERT_HEAD, plm_pkg::OP_INSERT_TAIL: begin
                        if (length_reg >= work_cap) begin
                            status_next = plm_pkg::ST_OVERFLOW;
                        end else begin
                            cmd.op      = plm_pkg::CELL_INSERT;
                            cmd.index   = (op_reg == plm_pkg::OP_INSERT_HEAD) ?
                                          '0 : length_reg[IDX_W-1:0];
                            length_next = length_reg + LEN_W'(1);
                        end
                    end
                    plm_pkg::OP_INSERT_AT: begin
                        if (length_reg >= work_cap) begin
                            status_next = plm_pkg::ST_OVERFLOW;
                        end else if (pos_bad_insert) begin
                            status_next = plm_pkg::ST_BAD_INDEX;
                        end else begin
                            cmd.op      = plm_pkg::CELL_INSERT;
                            cmd.index   = IDX_W'(pos_reg - LEN_W'(1));
                            length_next = length_reg + LEN_W'(1);
                        end
                    end
                    plm_pkg::OP_REMOVE_HEAD, plm_pkg::OP_REMOVE_TAIL: begin
                        if (list_is_empty) begin
                            status_next = plm_pkg::ST_UNDERFLOW;
                        end else begin
                            cmd.op      = plm_pkg::CELL_REMOVE;
                            cmd.index   = (op_reg == plm_pkg::OP_REMOVE_HEAD) ?
                                          '0 : last_index;
                            length_next = len_minus_one;
                        end
                    end
                    plm_pkg::OP_REMOVE_AT: begin
                        if (pos_bad_remove) begin
                            status_next = plm_pkg::ST_BAD_INDEX;
                        end else begin
                            cmd.op      = plm_pkg::CELL_REMOVE;
                            cmd.index   = IDX_W'(pos_reg - LEN_W'(1));
                            length_next = len_minus_one;
                        end
                    end
                    plm_pkg::OP_LIST_ALL: begin
                        // An empty list answers with one ordinary report beat.
                        if (!list_is_empty) begin
                            list_tail_next = tail_value;
                            count_next     = '0;
                            state_next     = plm_pkg::FSM_LIST;
                        end
                    end
                    default: begin
                        status_next = plm_pkg::ST_OK;
                    end
                endcase
            end
            plm_pkg::FSM_REPORT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tlast_next  = 1'b1;
                    m_tdata_next  = '0;
                    m_tdata_next[1:0]   = status_reg;
                    m_tdata_next[6:2]   = length_reg;
                    m_tdata_next[38:7]  = list_is_empty ? '0 : head_value;
                    m_tdata_next[70:39] = list_is_empty ? '0 : tail_value;
                    m_tdata_next[71]    = list_is_empty;
                    state_next = plm_pkg::FSM_IDLE;
                end
            end
            plm_pkg::FSM_LIST: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tlast_next  = list_last;
                    m_tdata_next  = '0;
                    m_tdata_next[1:0]   = plm_pkg::ST_OK;
                    m_tdata_next[6:2]   = length_reg;
                    m_tdata_next[38:7]  = head_value;
                    m_tdata_next[70:39] = list_tail_reg;
                    m_tdata_next[71]    = 1'b0;
                    // Rotating the occupied cells brings the next element to the head;
                    // after a full pass the row is back in its original order.
                    cmd.op     = plm_pkg::CELL_ROTATE;
                    cmd.index  = last_index;
                    count_next = count_reg + LEN_W'(1);
                    if (list_last) begin
                        state_next = plm_pkg::FSM_IDLE;
                    end
                end
            end
            default: begin
                state_next = plm_pkg::FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= plm_pkg::FSM_IDLE;
            length_reg   <= '0;
            capacity_reg <= LEN_W'(16);
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            length_reg   <= length_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                capacity_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        pos_reg       <= pos_next;
        val_reg       <= val_next;
        status_reg    <= status_next;
        count_reg     <= count_next;
        list_tail_reg <= list_tail_next;
        m_tdata_reg   <= m_tdata_next;
        m_tlast_reg   <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
